// File: rtl/bft_pkg.sv
`default_nettype none

package bft_pkg;

    // frame layout
    localparam logic [6:0] PREAMBLE_BITS = 7'd12;
    localparam logic [6:0] DATA_BITS     = 7'd32;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TICKS_W = 20;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_TICKS = 2'd3;

    // register reset values
    localparam logic [HALF_W-1:0]  BIT_TICKS_RST   = 16'd1400;
    localparam logic [HALF_W-1:0]  SYNC_TICKS_RST  = 16'd4200;
    localparam logic [TICKS_W-1:0] SPACE_TICKS_RST = 20'd10000;

    // input command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PRE  = 3'd1,
        PH_GAP  = 3'd2,
        PH_SYNC = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] raw_word;
    } bft_in_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } bft_out_t;

    typedef struct packed {
        logic               tx_enabled;
        logic [HALF_W-1:0]  bit_ticks;
        logic [HALF_W-1:0]  sync_ticks;
        logic [TICKS_W-1:0] space_ticks;
    } bft_cfg_t;

endpackage

`default_nettype wire

// File: rtl/bft_cfg_regs.sv
`default_nettype none

module bft_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [bft_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [bft_pkg::CFG_DATA_W-1:0]   wr_data,
    output bft_pkg::bft_cfg_t                     cfg
);
    import bft_pkg::*;

    bft_cfg_t cfg_reg;
    bft_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_TX_ENABLED:  cfg_next.tx_enabled  = wr_data[0];
                REG_BIT_TICKS:   cfg_next.bit_ticks   = wr_data[HALF_W-1:0];
                REG_SYNC_TICKS:  cfg_next.sync_ticks  = wr_data[HALF_W-1:0];
                REG_SPACE_TICKS: cfg_next.space_ticks = wr_data[TICKS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_enabled  <= 1'b0;
            cfg_reg.bit_ticks   <= BIT_TICKS_RST;
            cfg_reg.sync_ticks  <= SYNC_TICKS_RST;
            cfg_reg.space_ticks <= SPACE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/bft_seq.sv
`default_nettype none

module bft_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  bft_pkg::bft_in_t    item,
    input  bft_pkg::bft_cfg_t   cfg,
    output bft_pkg::bft_out_t   res
);
    import bft_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [INDEX_W-1:0]  bit_index_reg, bit_index_next;
    logic                second_half_reg, second_half_next;
    logic [TICKS_W-1:0]  ticks_left_reg, ticks_left_next;
    logic [WORD_W-1:0]   payload_reg, payload_next;

    logic [TICKS_W-1:0]  half_bit;
    logic [TICKS_W-1:0]  half_sync;
    logic [TICKS_W-1:0]  ticks_dec;
    logic [INDEX_W-1:0]  index_inc;
    logic                busy_now;

    // pin level for a given sequencer state
    function automatic logic level_of(
        input phase_t             ph,
        input logic               sh,
        input logic [INDEX_W-1:0] bi,
        input logic [WORD_W-1:0]  word
    );
        logic b;
        logic lvl;
        b = (bi[INDEX_W-1] == 1'b0) ? word[bi[INDEX_W-2:0]] : 1'b0;
        unique case (ph)
            PH_PRE, PH_SYNC: lvl = ~sh;
            PH_DATA:         lvl = b ? ~sh : sh;
            default:         lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    assign half_bit  = (cfg.bit_ticks == '0) ? TICKS_W'(1)
                                             : {{(TICKS_W-HALF_W){1'b0}}, cfg.bit_ticks};
    assign half_sync = (cfg.sync_ticks == '0) ? TICKS_W'(1)
                                              : {{(TICKS_W-HALF_W){1'b0}}, cfg.sync_ticks};
    assign ticks_dec = (ticks_left_reg == '0) ? '0 : ticks_left_reg - TICKS_W'(1);
    assign index_inc = bit_index_reg + INDEX_W'(1);
    assign busy_now  = (phase_reg != PH_IDLE);

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        second_half_next = second_half_reg;
        ticks_left_next  = ticks_left_reg;
        payload_next     = payload_reg;
        res.pin_level    = level_of(phase_reg, second_half_reg, bit_index_reg, payload_reg);
        res.busy_res     = busy_now;
        res.frame_done   = 1'b0;

        if (item.cmd == CMD_START)
        begin
            // start takes no time; result reflects the state after it
            if (!busy_now && cfg.tx_enabled)
            begin
                payload_next     = item.raw_word;
                phase_next       = PH_PRE;
                bit_index_next   = '0;
                second_half_next = 1'b0;
                ticks_left_next  = half_bit;
                res.pin_level    = 1'b1;
                res.busy_res     = 1'b1;
            end
        end
        else if (busy_now)
        begin
            ticks_left_next = ticks_dec;
            if (ticks_dec == '0)
            begin
                // segment used up: move on
                unique case (phase_reg)
                    PH_PRE, PH_DATA:
                    begin
                        if (!second_half_reg)
                        begin
                            second_half_next = 1'b1;
                            ticks_left_next  = half_bit;
                        end
                        else
                        begin
                            second_half_next = 1'b0;
                            bit_index_next   = index_inc;
                            if (phase_reg == PH_PRE && {1'b0, index_inc} >= PREAMBLE_BITS)
                            begin
                                bit_index_next = '0;
                                if (cfg.space_ticks == '0)
                                begin
                                    phase_next      = PH_SYNC;
                                    ticks_left_next = half_sync;
                                end
                                else
                                begin
                                    phase_next      = PH_GAP;
                                    ticks_left_next = cfg.space_ticks;
                                end
                            end
                            else if (phase_reg == PH_DATA &&
                                     ({1'b0, index_inc} >= DATA_BITS || index_inc == '0))
                            begin
                                phase_next      = PH_IDLE;
                                bit_index_next  = '0;
                                ticks_left_next = '0;
                                res.frame_done  = 1'b1;
                            end
                            else
                            begin
                                ticks_left_next = half_bit;
                            end
                        end
                    end
                    PH_GAP:
                    begin
                        phase_next       = PH_SYNC;
                        second_half_next = 1'b0;
                        ticks_left_next  = half_sync;
                    end
                    PH_SYNC:
                    begin
                        if (!second_half_reg)
                        begin
                            second_half_next = 1'b1;
                            ticks_left_next  = half_sync;
                        end
                        else
                        begin
                            phase_next       = PH_DATA;
                            second_half_next = 1'b0;
                            bit_index_next   = '0;
                            ticks_left_next  = half_bit;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            second_half_reg <= 1'b0;
            ticks_left_reg  <= '0;
            payload_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            second_half_reg <= second_half_next;
            ticks_left_reg  <= ticks_left_next;
            payload_reg     <= payload_next;
        end
    end

    // an active frame always has time left in its segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (ticks_left_reg != '0))
        else $error("bft_seq: active segment with no ticks left");

    // idle leaves counters cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (ticks_left_reg == '0 && bit_index_reg == '0
                                    && !second_half_reg))
        else $error("bft_seq: idle with stale counters");

    // a start during a frame leaves the payload alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.cmd == CMD_START && phase_reg != PH_IDLE) |=> $stable(payload_reg))
        else $error("bft_seq: payload changed by ignored start");

    // frame end reported only from the data phase and drops to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.frame_done) |-> (phase_reg == PH_DATA && phase_next == PH_IDLE))
        else $error("bft_seq: frame end outside data phase");

endmodule

`default_nettype wire

// File: rtl/biphase_frame_transmitter_top.sv
`default_nettype none

// biphase frame transmitter: every input beat is either a time tick or a
// start request carrying a 32-bit word, and every beat yields exactly one
// result beat with the pin level, the busy flag and the frame-end flag.
// a frame is twelve preamble ones (high/low, bit_ticks per half), a low gap
// of space_ticks, a sync pulse (high/low, sync_ticks per half) and 32 data
// bits lsb first (one = high then low, zero = low then high). starts are
// dropped while busy or while tx_enabled is clear. throughput is one beat per
// clock while out_ready holds: a beat lands in an input register, the frame
// sequencer updates its state and forms the result in one pass, and the
// result is held in an output register until it is taken. ready is
// combinational from out_ready through both stages; a beat is still taken
// while a result waits as long as the input register is empty.
// configuration writes are taken in any cycle (cfg_ready is tied high) and
// must only be issued while no frame or result beat is outstanding.

module biphase_frame_transmitter_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input beats
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  bft_pkg::bft_in_t                     in_item,
    // result beats
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output bft_pkg::bft_out_t                    out_item,
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bft_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bft_pkg::*;

    // input stage
    logic      in_vld_reg;
    bft_in_t   in_item_reg;
    // result stage
    logic      out_vld_reg;
    bft_out_t  out_item_reg;

    bft_cfg_t  cfg;
    bft_out_t  seq_res;
    logic      advance;

    // the buffered beat moves into the result register when that one is empty or being taken
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    bft_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // frame sequencer: state advances once per beat leaving the input stage
    bft_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= seq_res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire
